FILE: rtl/sbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants of the serial bank mapper.
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int SHIFT_BITS = 5;
    localparam int CNT_W      = 3;
    localparam int WIN_W      = 2;
    localparam int WINDOWS    = 4;
    localparam int OFFSET_W   = 21;
    localparam int SIZE_W     = 16;
    localparam int BANKS_W    = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;

    // Bit positions inside the written byte.
    localparam int CLEAR_BIT  = 7;
    localparam int SERIAL_BIT = 0;

    // Window register codes.
    localparam logic [WIN_W-1:0] REG_CTRL   = 2'd0;
    localparam logic [WIN_W-1:0] REG_CHR_LO = 2'd1;
    localparam logic [WIN_W-1:0] REG_CHR_HI = 2'd2;
    localparam logic [WIN_W-1:0] REG_PRG    = 2'd3;

    // Configuration register index.
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic [BANKS_W-1:0] PRG_BANK_COUNT_RESET = 6'd2;

    localparam logic [OFFSET_W-1:0] ROM_HEADER = 21'd16;

    localparam logic [SIZE_W-1:0] SIZE_32K = 16'd32768;
    localparam logic [SIZE_W-1:0] SIZE_16K = 16'd16384;
    localparam logic [SIZE_W-1:0] SIZE_8K  = 16'd8192;
    localparam logic [SIZE_W-1:0] SIZE_4K  = 16'd4096;

    localparam logic [ADDR_W-1:0] DEST_PRG_LOW  = 16'h8000;
    localparam logic [ADDR_W-1:0] DEST_PRG_HIGH = 16'hC000;
    localparam logic [ADDR_W-1:0] DEST_CHR_LOW  = 16'h0000;
    localparam logic [ADDR_W-1:0] DEST_CHR_HIGH = 16'h1000;

    typedef struct packed {
        logic                  valid;
        logic [WIN_W-1:0]      idx;
        logic [SHIFT_BITS-1:0] value;
    } commit_t;

    typedef struct packed {
        logic mirror;
        logic one_screen;
        logic prg_area;
        logic prg_small;
        logic chr_small;
    } ctrl_t;

    typedef struct packed {
        logic                valid;
        logic                target;
        logic [ADDR_W-1:0]   dest;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size;
    } load_t;

endpackage

FILE: rtl/sbm_shift_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_shift_bank
// Four serial shift registers, one per 8 KB window, with their bit counts.
// ----------------------------------------------------------------------------
module sbm_shift_bank
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [sbm_pkg::ADDR_W-1:0]    cpu_address,
    input  logic [sbm_pkg::DATA_W-1:0]    write_data,
    output sbm_pkg::commit_t              commit
);

    logic [sbm_pkg::SHIFT_BITS-1:0] value_reg [sbm_pkg::WINDOWS];
    logic [sbm_pkg::CNT_W-1:0]      count_reg [sbm_pkg::WINDOWS];

    logic [sbm_pkg::WIN_W-1:0]      win;
    logic                           active;
    logic                           clear;
    logic [sbm_pkg::CNT_W-1:0]      cur_count;
    logic [sbm_pkg::SHIFT_BITS-1:0] value_next;
    logic [sbm_pkg::CNT_W-1:0]      count_next;

    assign win       = cpu_address[sbm_pkg::ADDR_W-2 -: sbm_pkg::WIN_W];
    assign active    = cpu_address[sbm_pkg::ADDR_W-1];
    assign clear     = write_data[sbm_pkg::CLEAR_BIT];
    assign cur_count = count_reg[win];

    assign value_next = value_reg[win]
        | (sbm_pkg::SHIFT_BITS'(write_data[sbm_pkg::SERIAL_BIT]) << cur_count);
    assign count_next = cur_count + sbm_pkg::CNT_W'(1);

    always_comb
    begin
        commit.valid = active && !clear
                       && (cur_count == sbm_pkg::CNT_W'(sbm_pkg::SHIFT_BITS - 1));
        commit.idx   = win;
        commit.value = value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbm_pkg::WINDOWS; i++)
            begin
                value_reg[i] <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (step && active)
        begin
            if (clear || commit.valid)
            begin
                value_reg[win] <= '0;
                count_reg[win] <= '0;
            end
            else
            begin
                value_reg[win] <= value_next;
                count_reg[win] <= count_next;
            end
        end
    end

endmodule

FILE: rtl/sbm_load_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbm_load_calc
// Works out the ROM load (offset, size, destination) for one commit.
// ----------------------------------------------------------------------------
module sbm_load_calc
(
    input  sbm_pkg::commit_t                commit,
    input  sbm_pkg::ctrl_t                  ctrl,
    input  logic [sbm_pkg::BANKS_W-1:0]     prg_bank_count,
    output sbm_pkg::load_t                  load
);

    logic [sbm_pkg::OFFSET_W-1:0] val_ext;
    logic [sbm_pkg::OFFSET_W-1:0] chr_base;

    assign val_ext  = sbm_pkg::OFFSET_W'(commit.value);
    // CHR data follows the header and all 16 KB PRG banks.
    assign chr_base = sbm_pkg::ROM_HEADER
                      + (sbm_pkg::OFFSET_W'(prg_bank_count) << 14);

    always_comb
    begin
        load = '0;
        if (commit.valid)
        begin
            case (commit.idx) inside
                sbm_pkg::REG_PRG:
                begin
                    load.valid  = 1'b1;
                    load.target = 1'b0;
                    if (ctrl.prg_small)
                    begin
                        load.size   = sbm_pkg::SIZE_16K;
                        load.dest   = ctrl.prg_area ? sbm_pkg::DEST_PRG_LOW
                                                    : sbm_pkg::DEST_PRG_HIGH;
                        load.offset = sbm_pkg::ROM_HEADER + (val_ext << 14);
                    end
                    else
                    begin
                        load.size   = sbm_pkg::SIZE_32K;
                        load.dest   = sbm_pkg::DEST_PRG_LOW;
                        load.offset = sbm_pkg::ROM_HEADER + (val_ext << 15);
                    end
                end
                sbm_pkg::REG_CHR_LO, sbm_pkg::REG_CHR_HI:
                begin
                    // A zero bank number is reported but loads nothing.
                    if (commit.value != '0)
                    begin
                        load.valid  = 1'b1;
                        load.target = 1'b1;
                        if (ctrl.chr_small)
                        begin
                            load.size   = sbm_pkg::SIZE_4K;
                            load.dest   = (commit.idx == sbm_pkg::REG_CHR_HI)
                                          ? sbm_pkg::DEST_CHR_HIGH
                                          : sbm_pkg::DEST_CHR_LOW;
                            load.offset = chr_base + (val_ext << 12);
                        end
                        else
                        begin
                            load.size   = sbm_pkg::SIZE_8K;
                            load.dest   = sbm_pkg::DEST_CHR_LOW;
                            load.offset = chr_base + (val_ext << 13);
                        end
                    end
                end
                default:
                begin
                    load = '0;
                end
            endcase
        end
    end

endmodule

FILE: rtl/serial_bank_mapper_top.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result side holds back.
// Reset (rst_n, asynchronous, active low) clears all shift registers, counts and
// control flags, empties both stages, and sets prg_bank_count to 2.
// ----------------------------------------------------------------------------
// serial_bank_mapper_top
// Serial-loaded ROM bank switcher front end: takes CPU write words, shifts
// them into per-window registers and reports each commit and the ROM load
// it calls for.
// ----------------------------------------------------------------------------
module serial_bank_mapper_top
(
    input  logic                              clk,
    input  logic                              rst_n,

    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] cpu_address, [23:16] write_data
    input  logic [sbm_pkg::IN_TDATA_W-1:0]    s_tdata,

    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] commit_valid, [2:1] reg_index, [7:3] reg_value, [8] mirror_vertical,
    // [9] one_screen, [10] load_valid, [11] load_target, [27:12] dest_address,
    // [48:28] rom_offset, [64:49] window_size, [71:65] zero
    output logic [sbm_pkg::OUT_TDATA_W-1:0]   m_tdata,

    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // ------------------------------------------------------------------
    // Configuration register. The register index is the word address,
    // so byte address bits [1:0] are ignored.
    // ------------------------------------------------------------------
    logic [sbm_pkg::BANKS_W-1:0] prg_bank_count_reg;
    logic                        cfg_sel_banks;

    assign pready        = 1'b1;
    assign cfg_sel_banks = (paddr[2] == sbm_pkg::CFG_PRG_BANK_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= sbm_pkg::PRG_BANK_COUNT_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_sel_banks)
        begin
            prg_bank_count_reg <= pwdata[sbm_pkg::BANKS_W-1:0];
        end
    end

    assign prdata = cfg_sel_banks ? 32'(prg_bank_count_reg) : 32'd0;

    // ------------------------------------------------------------------
    // Input register. It moves on whenever the result register is free
    // or being emptied in the same cycle, so a word can enter every cycle.
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic [sbm_pkg::ADDR_W-1:0]    in_addr_reg;
    logic [sbm_pkg::DATA_W-1:0]    in_data_reg;
    logic                          out_valid_reg;
    logic [sbm_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                          out_adv;
    logic                          step;

    assign out_adv  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_addr_reg <= s_tdata[sbm_pkg::ADDR_W-1:0];
            in_data_reg <= s_tdata[sbm_pkg::ADDR_W +: sbm_pkg::DATA_W];
        end
    end

    // ------------------------------------------------------------------
    // Shift registers. State updates exactly when the buffered word
    // moves into the result register, which keeps words in order.
    // ------------------------------------------------------------------
    sbm_pkg::commit_t commit;

    sbm_shift_bank u_shift_bank
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cpu_address (in_addr_reg),
        .write_data  (in_data_reg),
        .commit      (commit)
    );

    // ------------------------------------------------------------------
    // Control flags, loaded by a commit to window 0. The flags reported
    // with a word are those after that word.
    // ------------------------------------------------------------------
    sbm_pkg::ctrl_t ctrl_reg;
    sbm_pkg::ctrl_t ctrl_next;
    logic           ctrl_commit;

    assign ctrl_commit = commit.valid && (commit.idx == sbm_pkg::REG_CTRL);

    always_comb
    begin
        ctrl_next = ctrl_reg;
        if (ctrl_commit)
        begin
            ctrl_next.mirror     = !commit.value[0];
            ctrl_next.one_screen = commit.value[1];
            ctrl_next.prg_area   = commit.value[2];
            ctrl_next.prg_small  = commit.value[3];
            ctrl_next.chr_small  = commit.value[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (step)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    // ------------------------------------------------------------------
    // ROM load for PRG and CHR commits. The page-size flags come from
    // the state before this word; a window-0 commit never loads.
    // ------------------------------------------------------------------
    sbm_pkg::load_t load;

    sbm_load_calc u_load_calc
    (
        .commit         (commit),
        .ctrl           (ctrl_reg),
        .prg_bank_count (prg_bank_count_reg),
        .load           (load)
    );

    // ------------------------------------------------------------------
    // Result register. A non-committing word reports zeros except for
    // the two mirroring flags.
    // ------------------------------------------------------------------
    logic [sbm_pkg::OUT_TDATA_W-1:0] result;
    logic [sbm_pkg::WIN_W-1:0]       res_idx;
    logic [sbm_pkg::SHIFT_BITS-1:0]  res_value;

    assign res_idx   = commit.valid ? commit.idx : '0;
    assign res_value = commit.valid ? commit.value : '0;

    assign result = {7'd0, load.size, load.offset, load.dest, load.target, load.valid,
                     ctrl_next.one_screen, ctrl_next.mirror, res_value, res_idx,
                     commit.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A ROM load is only ever reported together with a commit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> m_tdata[0])
        else $error("load reported without a commit");

    // A window-0 commit never asks for a ROM load.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && ctrl_commit |-> !load.valid)
        else $error("control commit produced a load");

    // The input side only stalls while a result waits on the output side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && in_valid_reg)
        else $error("input stalled with a free pipeline");

    // Control flags change only when a window-0 commit passes through.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(step && ctrl_commit) |=> $stable(ctrl_reg))
        else $error("control flags changed without a control commit");

endmodule

FILE: tb/sv/serial_bank_mapper_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_bank_mapper_top_tb
// Self-checking bench for the serial bank mapper. A directed burst covers
// ignored addresses, the clear bit, extreme register values and a zero CHR
// bank. Random five-write register loads mixed with stray, clear and ignored
// words follow, over several PRG bank-count settings and idle profiles. A
// scoreboard predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module serial_bank_mapper_top_tb;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_WORDS  = 65;
    localparam logic [sbm_pkg::CFG_ADDR_W-1:0] BANK_COUNT_ADDR =
        sbm_pkg::CFG_ADDR_W'(4 * sbm_pkg::CFG_PRG_BANK_COUNT);

    typedef logic [sbm_pkg::OFFSET_W-1:0] offset_t;

    // One result word, split into the fields the mapper reports.
    typedef struct packed {
        sbm_pkg::commit_t commit;
        logic             mirror;
        logic             one_screen;
        sbm_pkg::load_t   load;
    } mapper_result_t;

    // Scoreboard: holds its own copy of the mapper state, predicts the result
    // word of every accepted write and checks arriving result words in order.
    class mapper_scoreboard;
        mapper_result_t                 expected_q[$];
        logic [sbm_pkg::SHIFT_BITS-1:0] shift_val [sbm_pkg::WINDOWS];
        logic [sbm_pkg::CNT_W-1:0]      shift_cnt [sbm_pkg::WINDOWS];
        sbm_pkg::ctrl_t                 ctrl;
        logic [sbm_pkg::BANKS_W-1:0]    bank_count;
        int unsigned                    fail_count;
        int unsigned                    words_in;
        int unsigned                    results_seen;
        int unsigned                    commits;
        int unsigned                    loads;

        function new();
            foreach (shift_val[i])
            begin
                shift_val[i] = '0;
                shift_cnt[i] = '0;
            end
            ctrl         = '0;
            bank_count   = sbm_pkg::PRG_BANK_COUNT_RESET;
            fail_count   = 0;
            words_in     = 0;
            results_seen = 0;
            commits      = 0;
            loads        = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Called once for each write word accepted by the mapper.
        function void note_write(logic [sbm_pkg::ADDR_W-1:0] addr,
                                 logic [sbm_pkg::DATA_W-1:0] data);
            mapper_result_t                 res;
            logic [sbm_pkg::WIN_W-1:0]      win;
            logic [sbm_pkg::CNT_W-1:0]      cnt;
            logic [sbm_pkg::SHIFT_BITS-1:0] val;
            logic [sbm_pkg::SIZE_W-1:0]     size;
            res = '0;
            words_in++;
            if (addr[sbm_pkg::ADDR_W-1])
            begin
                win = addr[sbm_pkg::ADDR_W-2 -: sbm_pkg::WIN_W];
                if (data[sbm_pkg::CLEAR_BIT])
                begin
                    shift_val[win] = '0;
                    shift_cnt[win] = '0;
                end
                else
                begin
                    cnt = shift_cnt[win];
                    val = shift_val[win]
                        | (sbm_pkg::SHIFT_BITS'(data[sbm_pkg::SERIAL_BIT]) << cnt);
                    if (cnt != sbm_pkg::CNT_W'(sbm_pkg::SHIFT_BITS - 1))
                    begin
                        shift_val[win] = val;
                        shift_cnt[win] = cnt + 1'b1;
                    end
                    else
                    begin
                        // Fifth bit: the register commits and starts over.
                        shift_val[win]   = '0;
                        shift_cnt[win]   = '0;
                        res.commit.valid = 1'b1;
                        res.commit.idx   = win;
                        res.commit.value = val;
                        commits++;
                        if (win == sbm_pkg::REG_CTRL)
                        begin
                            ctrl.mirror     = ~val[0];
                            ctrl.one_screen = val[1];
                            ctrl.prg_area   = val[2];
                            ctrl.prg_small  = val[3];
                            ctrl.chr_small  = val[4];
                        end
                        else if (win == sbm_pkg::REG_PRG)
                        begin
                            res.load.valid  = 1'b1;
                            res.load.target = 1'b0;
                            if (ctrl.prg_small)
                            begin
                                size          = sbm_pkg::SIZE_16K;
                                res.load.dest = ctrl.prg_area ? sbm_pkg::DEST_PRG_LOW
                                                              : sbm_pkg::DEST_PRG_HIGH;
                            end
                            else
                            begin
                                size          = sbm_pkg::SIZE_32K;
                                res.load.dest = sbm_pkg::DEST_PRG_LOW;
                            end
                            res.load.size   = size;
                            res.load.offset = sbm_pkg::ROM_HEADER
                                            + offset_t'(val) * offset_t'(size);
                        end
                        else if (val != '0)
                        begin
                            res.load.valid  = 1'b1;
                            res.load.target = 1'b1;
                            if (ctrl.chr_small)
                            begin
                                size          = sbm_pkg::SIZE_4K;
                                res.load.dest = (win == sbm_pkg::REG_CHR_HI)
                                                ? sbm_pkg::DEST_CHR_HIGH
                                                : sbm_pkg::DEST_CHR_LOW;
                            end
                            else
                            begin
                                size          = sbm_pkg::SIZE_8K;
                                res.load.dest = sbm_pkg::DEST_CHR_LOW;
                            end
                            res.load.size   = size;
                            res.load.offset = sbm_pkg::ROM_HEADER
                                            + offset_t'(bank_count)
                                              * offset_t'(sbm_pkg::SIZE_16K)
                                            + offset_t'(val) * offset_t'(size);
                        end
                        if (res.load.valid)
                            loads++;
                    end
                end
            end
            res.mirror     = ctrl.mirror;
            res.one_screen = ctrl.one_screen;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                fail_count++;
            end
        endfunction

        // Called once for each result word accepted from the mapper.
        function void check_result(logic [sbm_pkg::OUT_TDATA_W-1:0] word);
            mapper_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result word 0x%0h arrived with no write waiting", word);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            compare_field("commit_valid",    want.commit.valid, word[0]);
            compare_field("reg_index",       want.commit.idx,   word[2:1]);
            compare_field("reg_value",       want.commit.value, word[7:3]);
            compare_field("mirror_vertical", want.mirror,       word[8]);
            compare_field("one_screen",      want.one_screen,   word[9]);
            compare_field("load_valid",      want.load.valid,   word[10]);
            compare_field("load_target",     want.load.target,  word[11]);
            compare_field("dest_address",    want.load.dest,    word[27:12]);
            compare_field("rom_offset",      want.load.offset,  word[48:28]);
            compare_field("window_size",     want.load.size,    word[64:49]);
            compare_field("tdata padding",   0,                 word[71:65]);
        endfunction
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic                               clk      = 1'b0;
    logic                               rst_n    = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [sbm_pkg::IN_TDATA_W-1:0]     s_tdata  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [sbm_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               psel     = 1'b0;
    logic                               penable  = 1'b0;
    logic                               pwrite   = 1'b0;
    logic [sbm_pkg::CFG_ADDR_W-1:0]     paddr    = '0;
    logic [31:0]                        pwdata   = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    mapper_scoreboard sb = new();

    // Percent of cycles in which each side holds back.
    int unsigned sender_idle_pct = 20;
    int unsigned recv_idle_pct   = 49;
    int unsigned cycle_count     = 0;

    serial_bank_mapper_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // [15:0] cpu_address, [23:16] write_data
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // [0] commit_valid, [2:1] reg_index, [7:3] reg_value, [8] mirror_vertical,
        // [9] one_screen, [10] load_valid, [11] load_target, [27:12] dest_address,
        // [48:28] rom_offset, [64:49] window_size, [71:65] zero
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Offers one write word, after a random number of idle cycles, and holds
    // it until the mapper takes it. Inputs move only on the falling edge, and
    // tvalid is left high so that the next word can follow back to back.
    task automatic send_word(input logic [sbm_pkg::ADDR_W-1:0] addr,
                             input logic [sbm_pkg::DATA_W-1:0] data);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        do @(posedge clk); while (!s_tready);
        sb.note_write(addr, data);
    endtask

    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // A complete five-write load of one window register, LSB first. The
    // unused address and data bits are random, so only bit 0 carries value.
    task automatic shift_in_register(input logic [sbm_pkg::WIN_W-1:0] win,
                                     input logic [sbm_pkg::SHIFT_BITS-1:0] value);
        for (int i = 0; i < sbm_pkg::SHIFT_BITS; i++)
            send_word({1'b1, win, 13'($urandom)}, {1'b0, 6'($urandom), value[i]});
    endtask

    // Mostly well-formed register loads with random content, mixed with clear
    // words, stray single bits that break up later loads, and ignored writes
    // below the mapper range (the latter are not counted).
    task automatic run_random_words(input int unsigned count);
        int unsigned sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 75)
            begin
                shift_in_register(sbm_pkg::WIN_W'($urandom_range(sbm_pkg::WINDOWS - 1)),
                                  sbm_pkg::SHIFT_BITS'($urandom));
                sent += sbm_pkg::SHIFT_BITS;
            end
            else
            begin
                case ($urandom_range(2))
                    0:
                        send_word({1'b0, 15'($urandom)}, 8'($urandom));
                    1:
                    begin
                        send_word({1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
                        sent++;
                    end
                    default:
                    begin
                        send_word({1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
                        sent++;
                    end
                endcase
            end
        end
    endtask

    // The sender stays quiet until every predicted result has been taken.
    task automatic drain_results();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BANK_COUNT_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_bank_count();
        logic [31:0] rdata;
        apb_access(1'b0, 32'd0, rdata);
        if (rdata[sbm_pkg::BANKS_W-1:0] != sb.bank_count)
        begin
            $error("prg_bank_count readback: expected 0x%0h, actual 0x%0h",
                   sb.bank_count, rdata[sbm_pkg::BANKS_W-1:0]);
            sb.fail_count++;
        end
    endtask

    task automatic write_bank_count(input logic [sbm_pkg::BANKS_W-1:0] value);
        logic [31:0] unused;
        apb_access(1'b1, 32'(value), unused);
        sb.bank_count = value;
        check_bank_count();
    endtask

    // Result side: tready changes on the falling edge, words are taken and
    // checked at the rising edge where tvalid and tready are both high.
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog: a run that is still going at the limit has hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [sbm_pkg::BANKS_W-1:0] bank_setting [SEGMENTS];
        bank_setting = '{6'd63, 6'd0, 6'd1, 6'd32,
                         sbm_pkg::BANKS_W'($urandom_range(2, 62)),
                         sbm_pkg::BANKS_W'($urandom_range(2, 62))};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The register comes out of reset at its documented value.
        check_bank_count();

        // Directed burst at the reset bank count. Writes below the mapper
        // range are ignored, whatever their data.
        send_word(16'h0000, 8'hFF);
        send_word(16'h7FFF, 8'h01);
        // Clear bit on the top address of the PRG window.
        send_word(16'hFFFF, 8'h80);
        // Control all ones: 16 KB PRG at the low half, 4 KB CHR, one-screen,
        // mirror flag cleared.
        shift_in_register(sbm_pkg::REG_CTRL, 5'h1F);
        shift_in_register(sbm_pkg::REG_PRG, 5'h1F);
        // A zero CHR value commits but loads nothing.
        shift_in_register(sbm_pkg::REG_CHR_HI, 5'h00);
        shift_in_register(sbm_pkg::REG_CHR_LO, 5'h1F);
        // Broken load: two bits, then a clear with every data bit set.
        send_word(16'hA000, 8'h01);
        send_word(16'hBFFF, 8'h7F);
        send_word(16'hA000, 8'hFF);
        end_burst();

        // Random segments, each at its own bank count. Every phase change
        // waits until the mapper is idle before the register is touched.
        for (int s = 0; s < SEGMENTS; s++)
        begin
            drain_results();
            write_bank_count(bank_setting[s]);
            if (s < 2)
            begin
                sender_idle_pct = 20;
                recv_idle_pct   = 49;
            end
            else if (s < 4)
            begin
                sender_idle_pct = 49;
                recv_idle_pct   = 20;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            run_random_words(SEGMENT_WORDS);
            end_burst();
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d write words and %0d result words: %0d commits, %0d ROM loads,",
                 sb.words_in, sb.results_seen, sb.commits, sb.loads);
        $display("over %0d bank-count settings and three idle profiles.", SEGMENTS + 1);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
